>>> rtl/grle_pkg.sv
// Shared types and constants for the gray-8 run-length stream decoder.
package grle_pkg;

    localparam int DIM_BITS = 16;
    localparam int LEN_BITS = 15;
    localparam int NODE_W   = 31;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [15:0] TAG_WORD     = 16'h3846;
    localparam logic [15:0] VERSION_WORD = 16'h3830;
    localparam logic [15:0] FMT_RAW_WORD = 16'h6130;
    localparam logic [15:0] FMT_RLE_WORD = 16'h6430;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } result_kind_t;

    typedef enum logic [3:0] {
        PH_TAG0   = 4'd0,
        PH_TAG1   = 4'd1,
        PH_VER0   = 4'd2,
        PH_VER1   = 4'd3,
        PH_FMT0   = 4'd4,
        PH_FMT1   = 4'd5,
        PH_WIDTH  = 4'd6,
        PH_HEIGHT = 4'd7,
        PH_COUNT  = 4'd8,
        PH_RAW    = 4'd9,
        PH_HEAD0  = 4'd10,
        PH_HEAD1  = 4'd11,
        PH_RUNVAL = 4'd12,
        PH_LIT    = 4'd13
    } phase_t;

    // arg packing: pixel -> {len, value} in [22:0]; header -> {height, width}
    typedef struct packed {
        result_kind_t kind;
        logic [31:0]  arg;
        logic         done;
    } token_t;

endpackage

>>> rtl/grle_front.sv
// Byte parser: walks the header and node structure and issues result tokens.
module grle_front
    import grle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] stream_byte,
    output logic       tok_valid,
    output token_t     tok
);

    phase_t               phase_reg, phase_next;
    logic [1:0]           idx_reg, idx_next;
    logic [23:0]          shift_reg, shift_next;
    logic                 run_mode_reg, run_mode_next;
    logic [DIM_BITS-1:0]  width_reg, width_next;
    logic [DIM_BITS-1:0]  col_left_reg, col_left_next;
    logic [DIM_BITS-1:0]  row_left_reg, row_left_next;
    logic [NODE_W-1:0]    nodes_left_reg, nodes_left_next;
    logic [LEN_BITS-1:0]  bytes_left_reg, bytes_left_next;

    logic [31:0]          word;
    logic                 last_byte;
    logic                 last_node;
    logic [LEN_BITS-1:0]  head_len;
    logic [NODE_W-1:0]    count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TAG0;
            idx_reg        <= '0;
            shift_reg      <= '0;
            run_mode_reg   <= 1'b0;
            width_reg      <= '0;
            col_left_reg   <= '0;
            row_left_reg   <= '0;
            nodes_left_reg <= '0;
            bytes_left_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            shift_reg      <= shift_next;
            run_mode_reg   <= run_mode_next;
            width_reg      <= width_next;
            col_left_reg   <= col_left_next;
            row_left_reg   <= row_left_next;
            nodes_left_reg <= nodes_left_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    assign word      = {stream_byte, shift_reg};
    assign last_byte = (idx_reg == 2'd3);
    assign last_node = (nodes_left_reg == NODE_W'(1));
    assign head_len  = {stream_byte[6:0], shift_reg[7:0]};
    assign count     = word[31] ? '0 : word[NODE_W-1:0];

    always_comb
    begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        shift_next      = shift_reg;
        run_mode_next   = run_mode_reg;
        width_next      = width_reg;
        col_left_next   = col_left_reg;
        row_left_next   = row_left_reg;
        nodes_left_next = nodes_left_reg;
        bytes_left_next = bytes_left_reg;
        tok_valid       = 1'b0;
        tok.kind        = KIND_ERROR;
        tok.arg         = '0;
        tok.done        = 1'b0;

        // byte gatherer for 32-bit little-endian fields
        if (!last_byte &&
            (phase_reg == PH_WIDTH || phase_reg == PH_HEIGHT || phase_reg == PH_COUNT))
        begin
            case (idx_reg)
                2'd0:    shift_next[7:0]   = stream_byte;
                2'd1:    shift_next[15:8]  = stream_byte;
                default: shift_next[23:16] = stream_byte;
            endcase
            idx_next = idx_reg + 2'd1;
        end

        unique case (phase_reg)
            PH_TAG0:
            begin
                if (stream_byte == TAG_WORD[7:0])
                    phase_next = PH_TAG1;
                else
                    tok_valid = 1'b1;
            end
            PH_TAG1:
            begin
                if (stream_byte == TAG_WORD[15:8])
                    phase_next = PH_VER0;
                else
                begin
                    phase_next = PH_TAG0;
                    tok_valid  = 1'b1;
                end
            end
            PH_VER0:
            begin
                if (stream_byte == VERSION_WORD[7:0])
                    phase_next = PH_VER1;
                else
                begin
                    phase_next = PH_TAG0;
                    tok_valid  = 1'b1;
                end
            end
            PH_VER1:
            begin
                if (stream_byte == VERSION_WORD[15:8])
                    phase_next = PH_FMT0;
                else
                begin
                    phase_next = PH_TAG0;
                    tok_valid  = 1'b1;
                end
            end
            PH_FMT0:
            begin
                if (stream_byte == FMT_RAW_WORD[7:0])
                    phase_next = PH_FMT1;
                else
                begin
                    phase_next = PH_TAG0;
                    tok_valid  = 1'b1;
                end
            end
            PH_FMT1:
            begin
                if (stream_byte == FMT_RAW_WORD[15:8])
                begin
                    run_mode_next = 1'b0;
                    phase_next    = PH_WIDTH;
                end
                else if (stream_byte == FMT_RLE_WORD[15:8])
                begin
                    run_mode_next = 1'b1;
                    phase_next    = PH_WIDTH;
                end
                else
                begin
                    phase_next = PH_TAG0;
                    tok_valid  = 1'b1;
                end
                idx_next   = '0;
                shift_next = '0;
            end
            PH_WIDTH:
            begin
                if (last_byte)
                begin
                    idx_next   = '0;
                    shift_next = '0;
                    if (word[31:DIM_BITS] != '0)
                    begin
                        phase_next = PH_TAG0;
                        tok_valid  = 1'b1;
                    end
                    else
                    begin
                        width_next = word[DIM_BITS-1:0];
                        phase_next = PH_HEIGHT;
                    end
                end
            end
            PH_HEIGHT:
            begin
                if (last_byte)
                begin
                    idx_next   = '0;
                    shift_next = '0;
                    if (word[31:DIM_BITS] != '0)
                    begin
                        phase_next = PH_TAG0;
                        tok_valid  = 1'b1;
                    end
                    else if (run_mode_reg)
                    begin
                        row_left_next = word[DIM_BITS-1:0];
                        phase_next    = PH_COUNT;
                    end
                    else
                    begin
                        // raw pixel count tracked as column and row countdowns
                        col_left_next = width_reg;
                        row_left_next = word[DIM_BITS-1:0];
                        tok_valid     = 1'b1;
                        tok.kind      = KIND_HEADER;
                        tok.arg       = {16'(word[DIM_BITS-1:0]), 16'(width_reg)};
                        tok.done      = (width_reg == '0) || (word[DIM_BITS-1:0] == '0);
                        phase_next    = tok.done ? PH_TAG0 : PH_RAW;
                    end
                end
            end
            PH_COUNT:
            begin
                if (last_byte)
                begin
                    idx_next        = '0;
                    shift_next      = '0;
                    nodes_left_next = count;
                    tok_valid       = 1'b1;
                    tok.kind        = KIND_HEADER;
                    tok.arg         = {16'(row_left_reg), 16'(width_reg)};
                    tok.done        = (count == '0);
                    phase_next      = tok.done ? PH_TAG0 : PH_HEAD0;
                end
            end
            PH_RAW:
            begin
                tok_valid = 1'b1;
                tok.kind  = KIND_PIXEL;
                tok.arg   = {9'd0, LEN_BITS'(1), stream_byte};
                tok.done  = (col_left_reg == DIM_BITS'(1)) && (row_left_reg == DIM_BITS'(1));
                if (col_left_reg == DIM_BITS'(1))
                begin
                    col_left_next = width_reg;
                    row_left_next = row_left_reg - DIM_BITS'(1);
                end
                else
                    col_left_next = col_left_reg - DIM_BITS'(1);
                if (tok.done)
                    phase_next = PH_TAG0;
            end
            PH_HEAD0:
            begin
                shift_next[7:0] = stream_byte;
                phase_next      = PH_HEAD1;
            end
            PH_HEAD1:
            begin
                shift_next      = '0;
                bytes_left_next = head_len;
                if (stream_byte[7])
                    phase_next = PH_RUNVAL;
                else if (head_len == '0)
                begin
                    nodes_left_next = nodes_left_reg - NODE_W'(1);
                    phase_next      = last_node ? PH_TAG0 : PH_HEAD0;
                end
                else
                    phase_next = PH_LIT;
            end
            PH_RUNVAL:
            begin
                bytes_left_next = '0;
                nodes_left_next = nodes_left_reg - NODE_W'(1);
                phase_next      = last_node ? PH_TAG0 : PH_HEAD0;
                // a zero-length run swallows its value byte
                tok_valid       = (bytes_left_reg != '0);
                tok.kind        = KIND_PIXEL;
                tok.arg         = {9'd0, bytes_left_reg, stream_byte};
                tok.done        = last_node;
            end
            PH_LIT:
            begin
                bytes_left_next = bytes_left_reg - LEN_BITS'(1);
                tok_valid       = 1'b1;
                tok.kind        = KIND_PIXEL;
                tok.arg         = {9'd0, LEN_BITS'(1), stream_byte};
                if (bytes_left_reg == LEN_BITS'(1))
                begin
                    nodes_left_next = nodes_left_reg - NODE_W'(1);
                    phase_next      = last_node ? PH_TAG0 : PH_HEAD0;
                    tok.done        = last_node;
                end
            end
            default:
            begin
                phase_next = PH_TAG0;
            end
        endcase
    end

endmodule

>>> rtl/grle_fifo.sv
// Short token queue between the parser and the result stage.
module grle_fifo
    import grle_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  token_t wr_tok,
    input  logic   rd_en,
    output token_t rd_tok,
    output logic   rd_valid,
    output logic   full
);

    token_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + QCNT_W'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_tok;
    end

    assign rd_tok   = mem_reg[rd_ptr_reg];
    assign rd_valid = (count_reg != '0);
    assign full     = (count_reg == QCNT_W'(QDEPTH));

endmodule

>>> rtl/grle_back.sv
// Result stage: unpacks tokens into result fields held in an output register.
module grle_back
    import grle_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_valid,
    input  token_t              tok,
    output logic                tok_take,
    input  logic                pop,
    output logic                empty,
    output logic [1:0]          result_kind,
    output logic [7:0]          pixel_value,
    output logic [LEN_BITS-1:0] repeat_count,
    output logic [15:0]         image_width,
    output logic [15:0]         image_height,
    output logic                image_done
);

    logic                valid_reg;
    result_kind_t        kind_reg;
    logic [7:0]          value_reg;
    logic [LEN_BITS-1:0] rep_reg;
    logic [15:0]         w_reg, h_reg;
    logic                done_reg;

    assign tok_take = tok_valid && (!valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || pop)
            valid_reg <= tok_valid;
    end

    always_ff @(posedge clk)
    begin
        if (tok_take)
        begin
            kind_reg  <= tok.kind;
            done_reg  <= tok.done;
            value_reg <= '0;
            rep_reg   <= '0;
            w_reg     <= '0;
            h_reg     <= '0;
            unique case (tok.kind)
                KIND_PIXEL:
                begin
                    value_reg <= tok.arg[7:0];
                    rep_reg   <= tok.arg[8 +: LEN_BITS];
                end
                KIND_HEADER:
                begin
                    w_reg <= tok.arg[15:0];
                    h_reg <= tok.arg[31:16];
                end
                default:
                begin
                    done_reg <= 1'b0;
                end
            endcase
        end
    end

    assign empty        = !valid_reg;
    assign result_kind  = kind_reg;
    assign pixel_value  = value_reg;
    assign repeat_count = rep_reg;
    assign image_width  = w_reg;
    assign image_height = h_reg;
    assign image_done   = done_reg;

endmodule

>>> rtl/gray8_rle_image_stream_decoder.sv
// Top level of the gray-8 image stream decoder (raw and run-length formats).
// A byte's result (if any) is written into the token queue, then into the output register once that is free.
// Throughput: one byte per cycle while the queue is not full; the parser state updates once per byte.
// A four-entry token queue lets the parser run while results wait for pop.
// Reset (rst_n low, async): parser waits for the first tag byte, queue and
// output register are emptied; empty reads high and full reads low.
module gray8_rle_image_stream_decoder
    import grle_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request input side
    input  logic                push,
    output logic                full,
    input  logic [7:0]          stream_byte,
    // result side
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          result_kind,
    output logic [7:0]          pixel_value,
    output logic [LEN_BITS-1:0] repeat_count,
    output logic [15:0]         image_width,
    output logic [15:0]         image_height,
    output logic                image_done
);

    logic   accept;
    logic   front_valid;
    token_t front_tok;
    logic   q_valid;
    token_t q_tok;
    logic   q_take;

    // a request is taken whenever the queue has room, even if the output waits
    assign accept = push && !full;

    // parser: header checks, field gathering, node bookkeeping
    grle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream_byte),
        .tok_valid   (front_valid),
        .tok         (front_tok)
    );

    // decouples the parser from the result consumer
    grle_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && front_valid),
        .wr_tok   (front_tok),
        .rd_en    (q_take),
        .rd_tok   (q_tok),
        .rd_valid (q_valid),
        .full     (full)
    );

    // output register, refilled in the same cycle it is popped
    grle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (q_valid),
        .tok          (q_tok),
        .tok_take     (q_take),
        .pop          (pop),
        .empty        (empty),
        .result_kind  (result_kind),
        .pixel_value  (pixel_value),
        .repeat_count (repeat_count),
        .image_width  (image_width),
        .image_height (image_height),
        .image_done   (image_done)
    );

endmodule

>>> rtl/grle_checker.sv
// Port-level checks for the decoder, bound to the top level.
module grle_checker
    import grle_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic [7:0]          stream_byte,
    input logic                empty,
    input logic                pop,
    input logic [1:0]          result_kind,
    input logic [7:0]          pixel_value,
    input logic [LEN_BITS-1:0] repeat_count,
    input logic [15:0]         image_width,
    input logic [15:0]         image_height,
    input logic                image_done
);

    // reset acts asynchronously; the idle state is checked via |=> after reset is seen low
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("queue not idle in reset");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_kind) && $stable(pixel_value)
            && $stable(repeat_count) && $stable(image_width)
            && $stable(image_height) && $stable(image_done)))
        else $error("waiting result changed");

    a_pixel_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_PIXEL) |->
            (repeat_count != '0 && image_width == '0 && image_height == '0))
        else $error("malformed pixel result");

    a_header_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_HEADER) |->
            (pixel_value == '0 && repeat_count == '0))
        else $error("malformed header result");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result_kind != 2'd3 &&
            (result_kind != KIND_ERROR || (!image_done && repeat_count == '0))))
        else $error("malformed error result");

endmodule

bind gray8_rle_image_stream_decoder grle_checker u_grle_checker (.*);
